FILE: rtl/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
// Included by the modules that check their own logic; needs clk and rst in scope.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Holds at every clock edge outside reset.
`define SPQ_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sorted_priority_queue: assertion failed");

// Overlapping implication outside reset.
`define SPQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_priority_queue: assertion failed");

// Next-cycle implication outside reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: assertion failed");

`else

`define SPQ_ASSERT(label, expr)
`define SPQ_ASSERT_IMP(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

  localparam int PRIO_WIDTH = 3;
  localparam int STATUS_WIDTH = 2;

  localparam logic [PRIO_WIDTH-1:0] PRIO_MIN = 3'd1;
  localparam logic [PRIO_WIDTH-1:0] PRIO_MAX = 3'd5;
  localparam logic [PRIO_WIDTH-1:0] PRIO_NONE = 3'd0;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP = 1'b1;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd2;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  // Out-of-range priorities saturate into PRIO_MIN..PRIO_MAX.
  function automatic logic [PRIO_WIDTH-1:0] clamp_prio(input logic [PRIO_WIDTH-1:0] p);
    logic [PRIO_WIDTH-1:0] r;
    r = p;
    if (p < PRIO_MIN) begin
      r = PRIO_MIN;
    end else if (p > PRIO_MAX) begin
      r = PRIO_MAX;
    end
    return r;
  endfunction

endpackage

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue: a row of spq_cell slots kept in ascending priority.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_assert.svh.
//
// Usage:
//   Request channel (req_valid/req_ready): req_type selects insert or pop;
//   entry_priority and entry_tag matter only for an insert.
//   Response channel (rsp_valid/rsp_ready): exactly one item per request with
//   status, the popped head_priority/head_tag (zero unless a pop succeeds)
//   and fill_count after the request.
//   Latency: the response is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while no held response stalls req_ready.
//   Every cell compares against the new priority in parallel and loads from
//   itself or a neighbor in the same edge, so the cell row never stalls.
//   Stall: the response sits in an output register; while it is not taken
//   req_ready stays low, and it rises again in the cycle the response leaves.
//   Reset: fill count goes to zero and the response register empties; slot
//   contents are not cleared since only occupied slots are ever read.
//   Errors: pop on empty returns status 1, insert on full returns status 2,
//   neither changes the stored entries.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              req_type,
  input  logic [spq_pkg::PRIO_WIDTH-1:0]    entry_priority,
  input  logic [TAG_WIDTH-1:0]              entry_tag,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [spq_pkg::STATUS_WIDTH-1:0]  status,
  output logic [spq_pkg::PRIO_WIDTH-1:0]    head_priority,
  output logic [TAG_WIDTH-1:0]              head_tag,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  fill_count
);

  `include "sorted_priority_queue_assert.svh"

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = spq_pkg::PRIO_WIDTH;

  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [PW-1:0]         new_prio;
  spq_pkg::cell_ctrl_t   ctrl;

  logic [QUEUE_DEPTH-1:0] take;
  logic [QUEUE_DEPTH-1:0] occ;
  logic [PW-1:0]          cell_prio [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0]   cell_tag  [QUEUE_DEPTH];

  logic [spq_pkg::STATUS_WIDTH-1:0] status_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (cnt == CW'(QUEUE_DEPTH));
  assign empty     = (cnt == '0);
  assign new_prio  = spq_pkg::clamp_prio(entry_priority);

  assign ctrl.ins = accept && (req_type == spq_pkg::REQ_INSERT) && !full;
  assign ctrl.pop = accept && (req_type == spq_pkg::REQ_POP) && !empty;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic          l_take;
      logic [PW-1:0] l_prio;
      logic [TAG_WIDTH-1:0] l_tag;
      logic [PW-1:0] r_prio;
      logic [TAG_WIDTH-1:0] r_tag;

      assign occ[i] = (CW'(i) < cnt);

      if (i == 0) begin : g_head
        // nothing ahead of the head: the new item lands here unless head stays
        assign l_take = 1'b1;
        assign l_prio = '0;
        assign l_tag  = '0;
      end else begin : g_body
        assign l_take = take[i-1];
        assign l_prio = cell_prio[i-1];
        assign l_tag  = cell_tag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign r_prio = '0;
        assign r_tag  = '0;
      end else begin : g_mid
        assign r_prio = cell_prio[i+1];
        assign r_tag  = cell_tag[i+1];
      end

      spq_cell #(
        .TAG_WIDTH(TAG_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ[i]),
        .new_prio   (new_prio),
        .new_tag    (entry_tag),
        .left_take  (l_take),
        .left_prio  (l_prio),
        .left_tag   (l_tag),
        .right_prio (r_prio),
        .right_tag  (r_tag),
        .take       (take[i]),
        .prio       (cell_prio[i]),
        .tag        (cell_tag[i])
      );
    end
  endgenerate

  always_comb begin
    cnt_next    = cnt;
    status_next = spq_pkg::STATUS_OK;
    if (req_type == spq_pkg::REQ_INSERT) begin
      if (full) begin
        status_next = spq_pkg::STATUS_FULL;
      end else begin
        cnt_next = cnt + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::STATUS_EMPTY;
      end else begin
        cnt_next = cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      fill_count <= cnt_next;
      if (ctrl.pop) begin
        head_priority <= cell_prio[0];
        head_tag      <= cell_tag[0];
      end else begin
        head_priority <= spq_pkg::PRIO_NONE;
        head_tag      <= '0;
      end
    end
  end

  `SPQ_ASSERT(a_cnt_bound, cnt <= CW'(QUEUE_DEPTH))
  `SPQ_ASSERT_NEXT(a_ins_grows, ctrl.ins, cnt == $past(cnt) + 1'b1)
  `SPQ_ASSERT_IMP(a_err_no_head, rsp_valid && (status != spq_pkg::STATUS_OK),
                  (head_priority == spq_pkg::PRIO_NONE) && (head_tag == '0))
  `SPQ_ASSERT_IMP(a_fill_match, rsp_valid && !$past(accept), fill_count == cnt)

  generate
    for (i = 1; i < QUEUE_DEPTH; i++) begin : g_order_chk
      `SPQ_ASSERT_IMP(a_sorted, occ[i], cell_prio[i-1] <= cell_prio[i])
    end
  endgenerate

endmodule

FILE: rtl/spq_cell.sv
// One slot of the shift-register queue: holds a priority and tag.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue.
module spq_cell #(
  parameter int TAG_WIDTH = 16
) (
  input  logic                            clk,
  input  spq_pkg::cell_ctrl_t             ctrl,
  input  logic                            occupied,
  input  logic [spq_pkg::PRIO_WIDTH-1:0]  new_prio,
  input  logic [TAG_WIDTH-1:0]            new_tag,
  input  logic                            left_take,
  input  logic [spq_pkg::PRIO_WIDTH-1:0]  left_prio,
  input  logic [TAG_WIDTH-1:0]            left_tag,
  input  logic [spq_pkg::PRIO_WIDTH-1:0]  right_prio,
  input  logic [TAG_WIDTH-1:0]            right_tag,
  output logic                            take,
  output logic [spq_pkg::PRIO_WIDTH-1:0]  prio,
  output logic [TAG_WIDTH-1:0]            tag
);

  // take: this entry stays ahead of the new one (ties stay in front)
  assign take = occupied && (prio <= new_prio);

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      prio <= right_prio;
      tag  <= right_tag;
    end else if (ctrl.ins && !take) begin
      if (left_take) begin
        prio <= new_prio;
        tag  <= new_tag;
      end else begin
        prio <= left_prio;
        tag  <= left_tag;
      end
    end
  end

endmodule
